// ===== rtl/core/msp_pkg.sv =====
// Shared types and constants for the mesh sensor status parser.
// Used by the front parser, the operation queue and the record builder.
`timescale 1ns / 1ps

package msp_pkg;

   localparam int NUM_SLOTS = 9;
   localparam int SLOT_W    = 4;
   localparam int VALUE_W   = 32;
   localparam int ADDR_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int ID_W      = 11;
   localparam int LEN_W     = 5;

   // Property ids of the known properties.
   localparam logic [ID_W-1:0] ID_SEQUENCE = 11'h7FF;
   localparam logic [ID_W-1:0] ID_TEMP     = 11'h04F;
   localparam logic [ID_W-1:0] ID_HUMIDITY = 11'h076;
   localparam logic [ID_W-1:0] ID_ECO2     = 11'h008;
   localparam logic [ID_W-1:0] ID_HEART    = 11'h100;
   localparam logic [ID_W-1:0] ID_SPO2     = 11'h101;
   localparam logic [ID_W-1:0] ID_TVOC     = 11'h102;
   localparam logic [ID_W-1:0] ID_RED      = 11'h103;
   localparam logic [ID_W-1:0] ID_IR       = 11'h104;

   // Record slots, which are also the bit positions of the present mask.
   localparam logic [SLOT_W-1:0] SLOT_SEQUENCE = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_TEMP     = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_HUMIDITY = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_ECO2     = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_TVOC     = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_HEART    = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_SPO2     = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_RED      = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_IR       = 4'd8;

   // Value lengths that carry a real value.
   localparam logic [LEN_W-1:0] LEN_ONE  = 5'd1;
   localparam logic [LEN_W-1:0] LEN_TWO  = 5'd2;
   localparam logic [LEN_W-1:0] LEN_FOUR = 5'd4;

   typedef enum logic [2:0] {
      PH_HDR_LO = 3'b001,
      PH_HDR_HI = 3'b010,
      PH_VALUE  = 3'b100
   } phase_type;

   typedef struct packed {
      logic              known;
      logic [SLOT_W-1:0] idx;
   } slot_sel_type;

   // One operation handed from the front parser to the record builder.
   typedef struct packed {
      logic               last;
      logic               commit;
      logic               scale;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic [ADDR_W-1:0]  sender;
   } op_type;

   function automatic slot_sel_type id_to_slot(input logic [ID_W-1:0] id);
      slot_sel_type sel;
      sel.known = 1'b1;
      sel.idx   = SLOT_SEQUENCE;
      unique case (id)
         ID_SEQUENCE: sel.idx = SLOT_SEQUENCE;
         ID_TEMP:     sel.idx = SLOT_TEMP;
         ID_HUMIDITY: sel.idx = SLOT_HUMIDITY;
         ID_ECO2:     sel.idx = SLOT_ECO2;
         ID_TVOC:     sel.idx = SLOT_TVOC;
         ID_HEART:    sel.idx = SLOT_HEART;
         ID_SPO2:     sel.idx = SLOT_SPO2;
         ID_RED:      sel.idx = SLOT_RED;
         ID_IR:       sel.idx = SLOT_IR;
         default:     sel.known = 1'b0;
      endcase
      return sel;
   endfunction

   // Trims the gathered bytes to the property length; lengths not 1, 2 or 4 give zero.
   function automatic logic [VALUE_W-1:0] sized_value(
      input logic [VALUE_W-1:0] acc,
      input logic [LEN_W-1:0]   len,
      input logic               sign
   );
      logic [VALUE_W-1:0] v;
      if (len == LEN_ONE) begin
         v = {{(VALUE_W-8){sign & acc[7]}}, acc[7:0]};
      end else if (len == LEN_TWO) begin
         v = {{(VALUE_W-16){sign & acc[15]}}, acc[15:0]};
      end else if (len == LEN_FOUR) begin
         v = acc;
      end else begin
         v = '0;
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/mesh_sensor_status_parser_top.sv =====
// Top level of the mesh sensor status parser: front parser, operation
// queue and record builder. Depends on msp_pkg, msp_front, msp_fifo, msp_back.
`timescale 1ns / 1ps

// The parser takes a sensor status message one byte per word on the req_
// channel, with req_last_byte marking the final byte and req_source_addr
// giving the sender. It accepts one byte every clock cycle for as long as its
// internal operation queue has room; the record builder handles one queued
// operation per cycle, save that an end-of-message operation waits while the
// previous record is not yet taken. At the last byte of a message that carried
// at least one known property, its end-of-message operation is queued and,
// once popped after the operations ahead of it, loads a single record into the
// rsp_ output register; a message with no known property yields no record.
// Values of properties not present read as zero. The queue (QUEUE_DEPTH
// words) lets bytes keep flowing while a finished record waits to be taken;
// only when the queue fills behind a stalled record does req_ready drop.
// There are no configuration registers.

module mesh_sensor_status_parser_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_msg_byte,
   input  logic                req_last_byte,
   input  logic [15:0]         req_source_addr,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_sender,
   output logic [8:0]          rsp_present_mask,
   output logic [31:0]         rsp_sequence_res,
   output logic signed [31:0]  rsp_temperature,
   output logic signed [31:0]  rsp_humidity,
   output logic [31:0]         rsp_eco2,
   output logic [31:0]         rsp_tvoc,
   output logic [31:0]         rsp_heart_rate,
   output logic signed [31:0]  rsp_spo2,
   output logic [31:0]         rsp_raw_red,
   output logic [31:0]         rsp_raw_ir
);
   import msp_pkg::*;

   op_type             push_op, pop_op;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   logic [VALUE_W-1:0] value [NUM_SLOTS];

   // Front: header and value parsing, one byte per cycle while the queue has room.
   msp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_msg_byte    (req_msg_byte),
      .req_last_byte   (req_last_byte),
      .req_source_addr (req_source_addr),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_op         (push_op)
   );

   // Queue decouples the parser from a stalled result consumer.
   msp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Back: record accumulation, scaling and the output register.
   msp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_op           (pop_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sender       (rsp_sender),
      .rsp_present_mask (rsp_present_mask),
      .rsp_value        (value)
   );

   // Record slots map onto the named result ports.
   assign rsp_sequence_res = value[SLOT_SEQUENCE];
   assign rsp_temperature  = signed'(value[SLOT_TEMP]);
   assign rsp_humidity     = signed'(value[SLOT_HUMIDITY]);
   assign rsp_eco2         = value[SLOT_ECO2];
   assign rsp_tvoc         = value[SLOT_TVOC];
   assign rsp_heart_rate   = value[SLOT_HEART];
   assign rsp_spo2         = signed'(value[SLOT_SPO2]);
   assign rsp_raw_red      = value[SLOT_RED];
   assign rsp_raw_ir       = value[SLOT_IR];

endmodule

// ===== rtl/core/msp_front.sv =====
// Front parser: takes message bytes, walks property headers and values,
// and emits commit and end-of-message operations. Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msp_pkg::BYTE_W-1:0]    req_msg_byte,
   input  logic                          req_last_byte,
   input  logic [msp_pkg::ADDR_W-1:0]    req_source_addr,
   output logic                          push_valid,
   input  logic                          push_ready,
   output msp_pkg::op_type               push_op
);
   import msp_pkg::*;

   phase_type                phase_ff, phase_in;
   logic                     stopped_ff, stopped_in;
   logic [BYTE_W-1:0]        header_low_ff, header_low_in;
   slot_sel_type             slot_ff, slot_in;
   logic [LEN_W-1:0]         length_ff, length_in;
   logic [LEN_W-1:0]         count_ff, count_in;
   logic [VALUE_W-1:0]       acc_ff, acc_in;
   logic                     accept;
   logic                     commit;
   logic [2*BYTE_W-1:0]      hdr;
   logic [VALUE_W-1:0]       lane;
   logic [VALUE_W-1:0]       gathered;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign hdr       = {req_msg_byte, header_low_ff};

   always_comb begin
      unique case (count_ff[1:0])
         2'd0:    lane = {24'd0, req_msg_byte};
         2'd1:    lane = {16'd0, req_msg_byte, 8'd0};
         2'd2:    lane = {8'd0, req_msg_byte, 16'd0};
         default: lane = {req_msg_byte, 24'd0};
      endcase
   end

   // Value bytes including the current one; only the first four are kept.
   assign gathered = (count_ff < LEN_W'(4)) ? (acc_ff | lane) : acc_ff;

   always_comb begin
      phase_in      = phase_ff;
      stopped_in    = stopped_ff;
      header_low_in = header_low_ff;
      slot_in       = slot_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      commit        = 1'b0;
      if (accept && !stopped_ff) begin
         unique case (phase_ff)
            PH_HDR_HI: begin
               if (hdr[0]) begin
                  // Format B header: ignore the rest of the message.
                  stopped_in = 1'b1;
                  phase_in   = PH_HDR_LO;
               end else begin
                  length_in = {1'b0, hdr[4:1]} + LEN_W'(1);
                  slot_in   = id_to_slot(hdr[15:5]);
                  count_in  = '0;
                  acc_in    = '0;
                  phase_in  = PH_VALUE;
               end
            end
            PH_VALUE: begin
               acc_in   = gathered;
               count_in = count_ff + LEN_W'(1);
               if (count_in >= length_ff) begin
                  commit   = 1'b1;
                  phase_in = PH_HDR_LO;
               end
            end
            default: begin
               header_low_in = req_msg_byte;
               phase_in      = PH_HDR_HI;
            end
         endcase
      end
      if (accept && req_last_byte) begin
         phase_in      = PH_HDR_LO;
         stopped_in    = 1'b0;
         header_low_in = '0;
         slot_in       = '0;
         length_in     = '0;
         count_in      = '0;
         acc_in        = '0;
      end
   end

   always_comb begin
      push_op.last   = req_last_byte;
      push_op.commit = commit && slot_ff.known;
      push_op.scale  = (slot_ff.idx == SLOT_TEMP) || (slot_ff.idx == SLOT_HUMIDITY)
                       || (slot_ff.idx == SLOT_SPO2);
      push_op.slot   = slot_ff.idx;
      push_op.value  = sized_value(gathered, length_ff, slot_ff.idx == SLOT_TEMP);
      push_op.sender = req_source_addr;
   end

   assign push_valid = accept && (push_op.commit || req_last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_LO;
         stopped_ff    <= 1'b0;
         header_low_ff <= '0;
         slot_ff       <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
         acc_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         stopped_ff    <= stopped_in;
         header_low_ff <= header_low_in;
         slot_ff       <= slot_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         acc_ff        <= acc_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> phase_ff == PH_HDR_LO && !stopped_ff && count_ff == '0)
      else $error("message state not cleared after last byte");

   a_stopped_phase: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> phase_ff == PH_HDR_LO)
      else $error("stopped parser left header phase");

endmodule

// ===== rtl/core/msp_fifo.sv =====
// Short operation queue between the front parser and the record builder.
// Depends on msp_pkg for the operation type.
`timescale 1ns / 1ps

module msp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  msp_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output msp_pkg::op_type pop_op
);
   import msp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_op     = entry_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count missed a push");

endmodule

// ===== rtl/core/msp_back.sv =====
// Record builder: applies committed values, scales flagged ones and loads the
// output register at message ends with a value present. Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  msp_pkg::op_type                pop_op,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [msp_pkg::ADDR_W-1:0]     rsp_sender,
   output logic [msp_pkg::NUM_SLOTS-1:0]  rsp_present_mask,
   output logic [msp_pkg::VALUE_W-1:0]    rsp_value [msp_pkg::NUM_SLOTS]
);
   import msp_pkg::*;

   logic [NUM_SLOTS-1:0] present_ff, present_in, merged_present;
   logic [VALUE_W-1:0]   val_ff [NUM_SLOTS];
   logic [VALUE_W-1:0]   merged_val [NUM_SLOTS];
   logic [VALUE_W-1:0]   scaled;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_sender_ff;
   logic [NUM_SLOTS-1:0] rsp_mask_ff;
   logic [VALUE_W-1:0]   rsp_value_ff [NUM_SLOTS];
   logic                 out_free, pop, emit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !pop_op.last || out_free;
   assign pop       = pop_valid && pop_ready;

   // Times ten, wrapping modulo 2^32.
   assign scaled = pop_op.scale ? (pop_op.value << 3) + (pop_op.value << 1) : pop_op.value;

   always_comb begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
         if (pop_op.commit && pop_op.slot == SLOT_W'(j)) begin
            merged_val[j]     = scaled;
            merged_present[j] = 1'b1;
         end else begin
            merged_val[j]     = val_ff[j];
            merged_present[j] = present_ff[j];
         end
      end
   end

   assign emit       = pop && pop_op.last && (merged_present != '0);
   assign present_in = !pop ? present_ff : (pop_op.last ? '0 : merged_present);

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int j = 0; j < NUM_SLOTS; j++) begin
            val_ff[j] <= merged_val[j];
         end
      end
      if (emit) begin
         rsp_sender_ff <= pop_op.sender;
         rsp_mask_ff   <= merged_present;
         for (int j = 0; j < NUM_SLOTS; j++) begin
            rsp_value_ff[j] <= merged_present[j] ? merged_val[j] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sender       = rsp_sender_ff;
   assign rsp_present_mask = rsp_mask_ff;
   assign rsp_value        = rsp_value_ff;

   a_record_nonempty: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && rsp_mask_ff != '0)
      else $error("record emitted with empty mask");

   a_message_end_clears: assert property (@(posedge clock) disable iff (reset)
      pop && pop_op.last |=> present_ff == '0)
      else $error("present bits survived end of message");

endmodule

// ===== dv/tb_mesh_sensor_status_parser_top.sv =====
// Self-checking testbench for mesh_sensor_status_parser_top: byte stream in,
// at most one status record out per message. Depends on msp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_mesh_sensor_status_parser_top;
   import msp_pkg::*;

   // Bench timing. The parser shows a record once its queued operations are
   // handled, so a short settle at the end is plenty.
   localparam int SETTLE_CYCLES = 10;
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_BYTES  = 950;
   localparam int IDLE_PERCENT  = 7;
   localparam int STEADY_FROM   = 300;
   localparam int STEADY_TO     = 600;
   localparam int DIRECTED_ROWS = 28;
   localparam logic [31:0] TENTHS = 32'd10;

   // One word of stimulus. Rows of the directed table may carry a typed
   // expectation on their last byte; random words never do.
   typedef struct packed {
      logic [7:0]        b;
      logic              last;
      logic [15:0]       addr;
      logic              typed;
      logic [8:0]        exp_mask;
      logic [SLOT_W-1:0] exp_slot;
      logic [31:0]       exp_val;
   } stim_word_type;

   // One status record as it appears on the rsp_ channel.
   typedef struct packed {
      logic [15:0]      sender;
      logic [8:0]       mask;
      logic [8:0][31:0] vals;
   } status_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_msg_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic [15:0] req_source_addr = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sender;
   logic [8:0]  rsp_present_mask;
   logic [31:0] rsp_sequence_res;
   logic signed [31:0] rsp_temperature;
   logic signed [31:0] rsp_humidity;
   logic [31:0] rsp_eco2;
   logic [31:0] rsp_tvoc;
   logic [31:0] rsp_heart_rate;
   logic signed [31:0] rsp_spo2;
   logic [31:0] rsp_raw_red;
   logic [31:0] rsp_raw_ir;

   stim_word_type  byte_q [$];
   status_rec_type record_q [$];
   stim_word_type  directed [DIRECTED_ROWS];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          quiet_cycles = 0;
   logic        steady;

   // The field names of the record slots, in slot order, for mismatch reports.
   string slot_names [9] = '{"rsp_sequence_res", "rsp_temperature", "rsp_humidity",
                             "rsp_eco2", "rsp_tvoc", "rsp_heart_rate", "rsp_spo2",
                             "rsp_raw_red", "rsp_raw_ir"};

   // Predictor state: the parse position within the current message and the
   // record being collected for it.
   phase_type   cur_phase = PH_HDR_LO;
   logic        halted = 1'b0;
   logic [7:0]  hdr_low = 8'h00;
   logic [10:0] prop_id = '0;
   logic [4:0]  prop_len = '0;
   logic [4:0]  prop_cnt = '0;
   logic [31:0] prop_acc = '0;
   logic [8:0]  seen_mask = '0;
   logic [8:0][31:0] slot_val = '0;

   mesh_sensor_status_parser_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_msg_byte     (req_msg_byte),
      .req_last_byte    (req_last_byte),
      .req_source_addr  (req_source_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sender       (rsp_sender),
      .rsp_present_mask (rsp_present_mask),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_temperature  (rsp_temperature),
      .rsp_humidity     (rsp_humidity),
      .rsp_eco2         (rsp_eco2),
      .rsp_tvoc         (rsp_tvoc),
      .rsp_heart_rate   (rsp_heart_rate),
      .rsp_spo2         (rsp_spo2),
      .rsp_raw_red      (rsp_raw_red),
      .rsp_raw_ir       (rsp_raw_ir)
   );

   always #5 clock = ~clock;

   // Neither side idles inside this window, so the parser also sees a long
   // run of back-to-back bytes and an always-ready receiver.
   assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

   // Cuts the gathered value bytes down to the property length. Only lengths
   // of one, two and four bytes carry a value; every other length reads zero.
   function automatic logic [31:0] trim_to_length(input logic [31:0] acc,
                                                  input logic [4:0] len,
                                                  input logic sgn);
      logic signed [7:0]  b8;
      logic signed [15:0] h16;
      logic signed [31:0] wide;
      b8 = acc[7:0];
      h16 = acc[15:0];
      wide = '0;
      if (len == LEN_ONE) begin
         if (sgn) wide = b8;
         else wide = acc[7:0];
      end else if (len == LEN_TWO) begin
         if (sgn) wide = h16;
         else wide = acc[15:0];
      end else if (len == LEN_FOUR) begin
         wide = acc;
      end
      return wide;
   endfunction

   // Files a finished property into its record slot. Temperature is the only
   // signed value; temperature, humidity and SpO2 are kept in tenths and wrap.
   task automatic commit_slot();
      logic [SLOT_W-1:0] slot;
      logic              known;
      logic              scaled;
      logic              sgn;
      logic [31:0]       v;
      known = 1'b1;
      scaled = 1'b0;
      sgn = 1'b0;
      slot = SLOT_SEQUENCE;
      case (prop_id)
         ID_SEQUENCE: slot = SLOT_SEQUENCE;
         ID_TEMP: begin
            slot = SLOT_TEMP;
            scaled = 1'b1;
            sgn = 1'b1;
         end
         ID_HUMIDITY: begin
            slot = SLOT_HUMIDITY;
            scaled = 1'b1;
         end
         ID_ECO2: slot = SLOT_ECO2;
         ID_TVOC: slot = SLOT_TVOC;
         ID_HEART: slot = SLOT_HEART;
         ID_SPO2: begin
            slot = SLOT_SPO2;
            scaled = 1'b1;
         end
         ID_RED: slot = SLOT_RED;
         ID_IR: slot = SLOT_IR;
         default: known = 1'b0;
      endcase
      if (known) begin
         v = trim_to_length(prop_acc, prop_len, sgn);
         if (scaled) v = v * TENTHS;
         slot_val[slot] = v;
         seen_mask[slot] = 1'b1;
      end
   endtask

   // Advances the parse by one accepted byte. On the last byte of a message it
   // hands back the record, if any known property was seen, and clears the
   // message state; the sender is the address that came with that last byte.
   task automatic take_byte(input logic [7:0] b, input logic last,
                            input logic [15:0] addr,
                            output logic has_rec, output status_rec_type rec);
      logic [15:0] hdr;
      has_rec = 1'b0;
      rec = '0;
      if (!halted) begin
         case (cur_phase)
            PH_HDR_HI: begin
               hdr = {b, hdr_low};
               if (hdr[0]) begin
                  // A format B header ends parsing for the rest of the message.
                  halted = 1'b1;
                  cur_phase = PH_HDR_LO;
               end else begin
                  prop_len = {1'b0, hdr[4:1]} + 5'd1;
                  prop_id = hdr[15:5];
                  prop_cnt = '0;
                  prop_acc = '0;
                  cur_phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               // Only the first four value bytes are gathered.
               if (prop_cnt < 5'd4)
                  prop_acc = prop_acc | ({24'd0, b} << (8 * prop_cnt));
               prop_cnt = prop_cnt + 5'd1;
               if (prop_cnt >= prop_len) begin
                  commit_slot();
                  cur_phase = PH_HDR_LO;
               end
            end
            default: begin
               hdr_low = b;
               cur_phase = PH_HDR_HI;
            end
         endcase
      end
      if (last) begin
         // A truncated property or a lone header byte is simply dropped here.
         if (seen_mask != '0) begin
            has_rec = 1'b1;
            rec.sender = addr;
            rec.mask = seen_mask;
            rec.vals = slot_val;
         end
         cur_phase = PH_HDR_LO;
         halted = 1'b0;
         hdr_low = '0;
         prop_id = '0;
         prop_len = '0;
         prop_cnt = '0;
         prop_acc = '0;
         seen_mask = '0;
         slot_val = '0;
      end
   endtask

   // Builds a format A header: mostly known ids, mostly real value lengths,
   // now and then any id and any length up to sixteen bytes.
   function automatic logic [15:0] make_header(output int len);
      logic [10:0] id;
      if ($urandom_range(0, 99) < 80) begin
         case ($urandom_range(0, 8))
            0: id = ID_SEQUENCE;
            1: id = ID_TEMP;
            2: id = ID_HUMIDITY;
            3: id = ID_ECO2;
            4: id = ID_TVOC;
            5: id = ID_HEART;
            6: id = ID_SPO2;
            7: id = ID_RED;
            default: id = ID_IR;
         endcase
      end else begin
         id = 11'($urandom);
      end
      if ($urandom_range(0, 99) < 70) begin
         case ($urandom_range(0, 2))
            0: len = 1;
            1: len = 2;
            default: len = 4;
         endcase
      end else begin
         len = $urandom_range(1, 16);
      end
      return {id, 4'(len - 1), 1'b0};
   endfunction

   // Queues one random message. Most are well-formed property lists with
   // random values, some end in a cut-off property or a stray header byte,
   // and the rest are plain noise.
   task automatic queue_random_message(output int n_bytes);
      logic [7:0]    msg [$];
      logic [15:0]   addr;
      logic [15:0]   hdr;
      stim_word_type w;
      int            kind;
      int            nprop;
      int            len;
      int            i;
      addr = 16'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         nprop = $urandom_range(1, 4);
         for (i = 0; i < nprop; i++) begin
            if ($urandom_range(0, 99) < 8) begin
               // Format B header followed by bytes the parser must ignore.
               hdr = 16'($urandom);
               hdr[0] = 1'b1;
               msg.push_back(hdr[7:0]);
               msg.push_back(hdr[15:8]);
               repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
               break;
            end
            hdr = make_header(len);
            msg.push_back(hdr[7:0]);
            msg.push_back(hdr[15:8]);
            repeat (len) msg.push_back(8'($urandom));
         end
         if (kind >= 75) begin
            if ($urandom_range(0, 1) == 0) begin
               msg.push_back(8'($urandom));
            end else begin
               hdr = make_header(len);
               msg.push_back(hdr[7:0]);
               msg.push_back(hdr[15:8]);
               repeat ($urandom_range(0, len - 1)) msg.push_back(8'($urandom));
            end
         end
      end else begin
         repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
      end
      for (i = 0; i < msg.size(); i++) begin
         w = '0;
         w.b = msg[i];
         w.last = (i == msg.size() - 1);
         w.addr = addr;
         byte_q.push_back(w);
      end
      n_bytes = msg.size();
   endtask

   // Compares the record on the rsp_ channel with the oldest expectation.
   task automatic check_record();
      status_rec_type want;
      status_rec_type got;
      int             i;
      got.sender = rsp_sender;
      got.mask = rsp_present_mask;
      got.vals[SLOT_SEQUENCE] = rsp_sequence_res;
      got.vals[SLOT_TEMP] = rsp_temperature;
      got.vals[SLOT_HUMIDITY] = rsp_humidity;
      got.vals[SLOT_ECO2] = rsp_eco2;
      got.vals[SLOT_TVOC] = rsp_tvoc;
      got.vals[SLOT_HEART] = rsp_heart_rate;
      got.vals[SLOT_SPO2] = rsp_spo2;
      got.vals[SLOT_RED] = rsp_raw_red;
      got.vals[SLOT_IR] = rsp_raw_ir;
      if (record_q.size() == 0) begin
         $error("record with no expectation waiting, rsp_sender %h", rsp_sender);
         mismatch_count++;
      end else begin
         want = record_q.pop_front();
         if (got.sender !== want.sender) begin
            $error("rsp_sender: expected %h, got %h", want.sender, got.sender);
            mismatch_count++;
         end
         if (got.mask !== want.mask) begin
            $error("rsp_present_mask: expected %h, got %h", want.mask, got.mask);
            mismatch_count++;
         end
         for (i = 0; i < 9; i++) begin
            if (got.vals[i] !== want.vals[i]) begin
               $error("%s: expected %h, got %h", slot_names[i], want.vals[i],
                      got.vals[i]);
               mismatch_count++;
            end
         end
      end
   endtask

   // Byte sender. The word on the req_ lines is always the head of the byte
   // queue; it is popped and run through the predictor when it is taken. A
   // new word goes out only after the previous one was taken, so valid never
   // drops and the payload never changes while a word is waiting.
   always @(posedge clock) begin : drive_req
      logic           taken;
      logic           has_rec;
      status_rec_type rec;
      stim_word_type  w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            w = byte_q.pop_front();
            take_byte(w.b, w.last, w.addr, has_rec, rec);
            if (w.typed) begin
               // Directed rows state their record outright.
               if (w.exp_mask != '0) begin
                  rec = '0;
                  rec.sender = w.addr;
                  rec.mask = w.exp_mask;
                  rec.vals[w.exp_slot] = w.exp_val;
                  record_q.push_back(rec);
               end
            end else if (has_rec) begin
               record_q.push_back(rec);
            end
         end
         if (!req_valid || taken) begin
            if (byte_q.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_valid <= 1'b1;
               req_msg_byte <= byte_q[0].b;
               req_last_byte <= byte_q[0].last;
               req_source_addr <= byte_q[0].addr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Record receiver: checks each taken record and stalls now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_record();
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a run of cycles with no word moving on either channel means
   // the parser has hung.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : main
      int i;
      int n_bytes;
      int random_bytes;

      // Directed messages: byte, last, sender, typed, mask, slot, value.
      // 1. Temperature of -128 in one byte, scaled to tenths and sign-extended.
      // 2. Sequence number at its maximum, four bytes.
      // 3. eCO2 then a format B header; the trailing byte is ignored.
      // 4. Unknown property only, so no record comes out.
      // 5. Humidity at its two-byte maximum, then a lone header byte dropped.
      // 6. Heart rate with a three-byte value: present, but zero.
      directed = '{
         '{8'hE0, 1'b0, 16'hFFFF, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h09, 1'b0, 16'hFFFF, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h80, 1'b1, 16'hFFFF, 1'b1, 9'h002, SLOT_TEMP,     32'hFFFFFB00},
         '{8'hE6, 1'b0, 16'h0000, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h0000, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h0000, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h0000, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h0000, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b1, 16'h0000, 1'b1, 9'h001, SLOT_SEQUENCE, 32'hFFFFFFFF},
         '{8'h00, 1'b0, 16'hA5C3, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h01, 1'b0, 16'hA5C3, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h7F, 1'b0, 16'hA5C3, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h01, 1'b0, 16'hA5C3, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'hA5C3, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h55, 1'b1, 16'hA5C3, 1'b1, 9'h008, SLOT_ECO2,     32'h0000007F},
         '{8'h00, 1'b0, 16'h5A3C, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h00, 1'b0, 16'h5A3C, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hAA, 1'b1, 16'h5A3C, 1'b1, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hC2, 1'b0, 16'h1234, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h0E, 1'b0, 16'h1234, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h1234, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'hFF, 1'b0, 16'h1234, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h4F, 1'b1, 16'h1234, 1'b1, 9'h004, SLOT_HUMIDITY, 32'h0009FFF6},
         '{8'h04, 1'b0, 16'h8001, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h20, 1'b0, 16'h8001, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h11, 1'b0, 16'h8001, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h22, 1'b0, 16'h8001, 1'b0, 9'h000, SLOT_SEQUENCE, 32'h0},
         '{8'h33, 1'b1, 16'h8001, 1'b1, 9'h020, SLOT_HEART,    32'h0}
      };
      for (i = 0; i < DIRECTED_ROWS; i++) byte_q.push_back(directed[i]);

      // The random messages are queued up front; the sender drains them.
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         queue_random_message(n_bytes);
         random_bytes += n_bytes;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken, then for every record to arrive.
      while (byte_q.size() != 0 || req_valid) @(posedge clock);
      while (record_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && record_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/msp_pkg.sv
rtl/core/msp_front.sv
rtl/core/msp_fifo.sv
rtl/core/msp_back.sv
rtl/core/mesh_sensor_status_parser_top.sv
dv/tb_mesh_sensor_status_parser_top.sv
